// ===== rtl/bemi_pkg.sv =====
`timescale 1ns / 1ps
// Package for the bending energy block: item types, register indexes, constants.
// No dependencies; imported by bending_energy_min_image.
package bemi_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_BEND_STIFFNESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_X         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_Y         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_Z         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_EDGE_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_EDGE_Y     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INV_EDGE_Z     = 3'd6;

  // Width used to compare a bead index against the chain length (up to 65536)
  localparam int IDX_CMP_W = 17;

  // One half in the Q.38 wrap product, one half in the Q.24 energy product
  localparam logic signed [49:0] WRAP_HALF   = 50'sh0_0020_0000_0000;
  localparam logic [50:0]        ENERGY_HALF = 51'h0_0000_0080_0000;

  // Largest energy code and wrapped component bounds
  localparam logic [26:0]        ENERGY_MAX = 27'h1FF_FFFF;
  localparam logic signed [36:0] WRAP_HI    = 37'sh0_01FF_FFFF;
  localparam logic signed [36:0] WRAP_LO    = -37'sh0_0200_0000;

  // Input item: bead index and the three positions
  typedef struct packed {
    logic        [9:0]  index_in_chain;
    logic signed [23:0] a_x;
    logic signed [23:0] a_y;
    logic signed [23:0] a_z;
    logic signed [23:0] b_x;
    logic signed [23:0] b_y;
    logic signed [23:0] b_z;
    logic signed [23:0] c_x;
    logic signed [23:0] c_y;
    logic signed [23:0] c_z;
  } bemi_in_t;

  // Result item
  typedef struct packed {
    logic [24:0] bend_energy;
    logic        zero_bond;
  } bemi_out_t;

endpackage

// ===== rtl/bending_energy_min_image.sv =====
`timescale 1ns / 1ps
// Bending energy of a bead triple with minimum-image wrap, fully pipelined.
// Depends on bemi_pkg.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------
//   in_     | input     | in_valid/in_stall  | bemi_in_t  in_data
//   out_    | output    | out_valid/out_stall| bemi_out_t out_data
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item enters per cycle unless in_stall is high.
// The depth is set by the 31-stage square root and the 26-stage divider.
// A two-entry output queue takes results while out_stall is high; the whole
// pipeline freezes only when that queue is full, so nothing is lost or repeated.
// rst_n (synchronous) clears valid bits, the queue count and the config registers.
module bending_energy_min_image #(
  parameter int CHAIN_LEN = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bemi_pkg::bemi_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bemi_pkg::bemi_out_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bemi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bemi_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bemi_pkg::*;

  localparam int SQ_N   = 31;   // root bits
  localparam int NRM_N  = 5;    // shift steps 16, 8, 4, 2, 1
  localparam int DV_N   = 26;   // quotient bits
  localparam int NSTAGE = 6 + SQ_N + 2 + NRM_N + 1 + DV_N + 1;

  typedef struct packed {
    logic kill;   // early zero result
    logic zb;     // zero-length bond
  } flag_t;

  // ---------------- configuration registers ----------------
  logic [23:0] stiff_r;
  logic [22:0] edge_r [3];
  logic [23:0] inv_r  [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiff_r <= '0;
      for (int a = 0; a < 3; a++) begin
        edge_r[a] <= '0;
        inv_r[a]  <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BEND_STIFFNESS: stiff_r   <= cfg_data;
        REG_EDGE_X:         edge_r[0] <= cfg_data[22:0];
        REG_EDGE_Y:         edge_r[1] <= cfg_data[22:0];
        REG_EDGE_Z:         edge_r[2] <= cfg_data[22:0];
        REG_INV_EDGE_X:     inv_r[0]  <= cfg_data;
        REG_INV_EDGE_Y:     inv_r[1]  <= cfg_data;
        REG_INV_EDGE_Z:     inv_r[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- output queue and pipeline enable ----------------
  bemi_out_t   fifo_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        en, in_acc, push, pop;
  logic [NSTAGE-1:0] valid_r;
  bemi_out_t   res_nxt;

  assign en       = (cnt_r != 2'd2);
  assign in_stall = !en;
  assign in_acc   = in_valid && en;
  assign push     = en && valid_r[NSTAGE-1];
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = fifo_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
      valid_r  <= '0;
    end else begin
      if (en) valid_r <= {valid_r[NSTAGE-2:0], in_acc};
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= res_nxt;
  end

  // ---------------- stage 1: differences and early-out ----------------
  logic signed [24:0] s1_d_r [6];   // BA x,y,z then CB x,y,z
  flag_t              s1_f_r;
  logic signed [24:0] s1_d_nxt [6];
  logic [IDX_CMP_W-1:0] idx_ext;

  assign idx_ext = {{(IDX_CMP_W-10){1'b0}}, in_data.index_in_chain};

  always_comb begin
    s1_d_nxt[0] = 25'(in_data.b_x) - 25'(in_data.a_x);
    s1_d_nxt[1] = 25'(in_data.b_y) - 25'(in_data.a_y);
    s1_d_nxt[2] = 25'(in_data.b_z) - 25'(in_data.a_z);
    s1_d_nxt[3] = 25'(in_data.c_x) - 25'(in_data.b_x);
    s1_d_nxt[4] = 25'(in_data.c_y) - 25'(in_data.b_y);
    s1_d_nxt[5] = 25'(in_data.c_z) - 25'(in_data.b_z);
  end

  // ---------------- stages 2..4: minimum-image wrap ----------------
  logic signed [49:0] s2_t_r  [6];
  logic signed [24:0] s2_d_r  [6];
  flag_t              s2_f_r;
  logic signed [35:0] s3_ne_r [6];
  logic signed [24:0] s3_d_r  [6];
  flag_t              s3_f_r;
  logic signed [25:0] s4_w_r  [6];
  flag_t              s4_f_r;

  logic signed [49:0] s2_t_nxt  [6];
  logic signed [49:0] s3_sum    [6];
  logic signed [11:0] s3_n      [6];
  logic signed [35:0] s3_ne_nxt [6];
  logic signed [36:0] s4_diff   [6];
  logic signed [25:0] s4_w_nxt  [6];

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      // d * inv in Q.38
      s2_t_nxt[j]  = s1_d_r[j] * $signed({1'b0, inv_r[j % 3]});
      // round to nearest box count, then count * edge
      s3_sum[j]    = s2_t_r[j] + WRAP_HALF;
      s3_n[j]      = 12'(s3_sum[j] >>> 38);
      s3_ne_nxt[j] = s3_n[j] * $signed({1'b0, edge_r[j % 3]});
      // wrapped component with saturation
      s4_diff[j]   = 37'(s3_d_r[j]) - 37'(s3_ne_r[j]);
      if (s4_diff[j] > WRAP_HI)      s4_w_nxt[j] = 26'(WRAP_HI);
      else if (s4_diff[j] < WRAP_LO) s4_w_nxt[j] = 26'(WRAP_LO);
      else                           s4_w_nxt[j] = 26'(s4_diff[j]);
    end
  end

  // ---------------- stages 5..6: squares, dot product, sums ----------------
  logic signed [51:0] s5_p_r [9];   // BA^2 x,y,z ; CB^2 x,y,z ; BA.CB x,y,z
  flag_t              s5_f_r;
  logic [51:0]        s6_l1_r, s6_l2_r;
  logic signed [53:0] s6_dot_r;
  flag_t              s6_f_r;

  logic signed [51:0] s5_p_nxt [9];
  logic signed [53:0] s6_l1_sum, s6_l2_sum, s6_dot_sum;
  flag_t              s6_f_nxt;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      s5_p_nxt[a]     = s4_w_r[a]     * s4_w_r[a];
      s5_p_nxt[3 + a] = s4_w_r[3 + a] * s4_w_r[3 + a];
      s5_p_nxt[6 + a] = s4_w_r[a]     * s4_w_r[3 + a];
    end
    s6_l1_sum  = 54'(s5_p_r[0]) + 54'(s5_p_r[1]) + 54'(s5_p_r[2]);
    s6_l2_sum  = 54'(s5_p_r[3]) + 54'(s5_p_r[4]) + 54'(s5_p_r[5]);
    s6_dot_sum = 54'(s5_p_r[6]) + 54'(s5_p_r[7]) + 54'(s5_p_r[8]);
    s6_f_nxt.kill = s5_f_r.kill;
    s6_f_nxt.zb   = !s5_f_r.kill && (s6_l1_sum == '0 || s6_l2_sum == '0);
  end

  // ---------------- square root: one root bit per stage, both bonds ----------------
  logic [61:0]        sq_rem1_r [SQ_N];
  logic [61:0]        sq_rem2_r [SQ_N];
  logic [30:0]        sq_rt1_r  [SQ_N];
  logic [30:0]        sq_rt2_r  [SQ_N];
  logic signed [53:0] sq_dot_r  [SQ_N];
  flag_t              sq_f_r    [SQ_N];

  logic [61:0] sq_rem1_src [SQ_N];
  logic [61:0] sq_rem2_src [SQ_N];
  logic [30:0] sq_rt1_src  [SQ_N];
  logic [30:0] sq_rt2_src  [SQ_N];
  logic [62:0] sq_trial1   [SQ_N];
  logic [62:0] sq_trial2   [SQ_N];
  logic [61:0] sq_rem1_nxt [SQ_N];
  logic [61:0] sq_rem2_nxt [SQ_N];
  logic [30:0] sq_rt1_nxt  [SQ_N];
  logic [30:0] sq_rt2_nxt  [SQ_N];

  always_comb begin
    sq_rem1_src[0] = {s6_l1_r, 10'b0};
    sq_rem2_src[0] = {s6_l2_r, 10'b0};
    sq_rt1_src[0]  = '0;
    sq_rt2_src[0]  = '0;
    for (int j = 1; j < SQ_N; j++) begin
      sq_rem1_src[j] = sq_rem1_r[j-1];
      sq_rem2_src[j] = sq_rem2_r[j-1];
      sq_rt1_src[j]  = sq_rt1_r[j-1];
      sq_rt2_src[j]  = sq_rt2_r[j-1];
    end
    for (int j = 0; j < SQ_N; j++) begin
      // stage j decides root bit (SQ_N-1-j)
      sq_trial1[j] = (63'(sq_rt1_src[j]) << (SQ_N - j))
                   | (63'(1) << (2 * (SQ_N - 1 - j)));
      sq_trial2[j] = (63'(sq_rt2_src[j]) << (SQ_N - j))
                   | (63'(1) << (2 * (SQ_N - 1 - j)));
      sq_rem1_nxt[j] = sq_rem1_src[j];
      sq_rt1_nxt[j]  = sq_rt1_src[j];
      if ({1'b0, sq_rem1_src[j]} >= sq_trial1[j]) begin
        sq_rem1_nxt[j] = 62'({1'b0, sq_rem1_src[j]} - sq_trial1[j]);
        sq_rt1_nxt[j]  = sq_rt1_src[j] | (31'(1) << (SQ_N - 1 - j));
      end
      sq_rem2_nxt[j] = sq_rem2_src[j];
      sq_rt2_nxt[j]  = sq_rt2_src[j];
      if ({1'b0, sq_rem2_src[j]} >= sq_trial2[j]) begin
        sq_rem2_nxt[j] = 62'({1'b0, sq_rem2_src[j]} - sq_trial2[j]);
        sq_rt2_nxt[j]  = sq_rt2_src[j] | (31'(1) << (SQ_N - 1 - j));
      end
    end
  end

  // ---------------- length product and numerator ----------------
  logic [61:0]        dn_den_r;
  logic signed [53:0] dn_dot_r;
  flag_t              dn_f_r;
  logic [62:0]        nu_num_r;
  logic [61:0]        nu_den_r;
  flag_t              nu_f_r;

  logic signed [65:0] nu_diff;
  logic [62:0]        nu_num_nxt;

  always_comb begin
    // den - dot * 2^10, floored at zero
    nu_diff = $signed({4'b0, dn_den_r}) - (66'(dn_dot_r) <<< 10);
    nu_num_nxt = nu_diff[65] ? '0 : 63'(nu_diff);
  end

  // ---------------- normalize den below 2^32 ----------------
  logic [62:0] nm_num_r [NRM_N];
  logic [61:0] nm_den_r [NRM_N];
  flag_t       nm_f_r   [NRM_N];

  logic [62:0] nm_num_src [NRM_N];
  logic [61:0] nm_den_src [NRM_N];
  logic [62:0] nm_num_nxt [NRM_N];
  logic [61:0] nm_den_nxt [NRM_N];

  always_comb begin
    nm_num_src[0] = nu_num_r;
    nm_den_src[0] = nu_den_r;
    for (int j = 1; j < NRM_N; j++) begin
      nm_num_src[j] = nm_num_r[j-1];
      nm_den_src[j] = nm_den_r[j-1];
    end
    for (int j = 0; j < NRM_N; j++) begin
      // shift by s when den still needs at least s more shifts
      if (nm_den_src[j] >= (62'(1) << (31 + (16 >> j)))) begin
        nm_num_nxt[j] = nm_num_src[j] >> (16 >> j);
        nm_den_nxt[j] = nm_den_src[j] >> (16 >> j);
      end else begin
        nm_num_nxt[j] = nm_num_src[j];
        nm_den_nxt[j] = nm_den_src[j];
      end
    end
  end

  // ---------------- clamp numerator to 2 * den ----------------
  logic [32:0] cl_num_r;
  logic [31:0] cl_den_r;
  flag_t       cl_f_r;
  logic [32:0] cl_twice;
  logic [32:0] cl_num_nxt;

  always_comb begin
    cl_twice   = {nm_den_r[NRM_N-1][31:0], 1'b0};
    cl_num_nxt = (nm_num_r[NRM_N-1] > 63'(cl_twice)) ? cl_twice
                                                      : 33'(nm_num_r[NRM_N-1]);
  end

  // ---------------- divider: one quotient bit per stage ----------------
  logic [57:0] dv_rem_r [DV_N];
  logic [25:0] dv_q_r   [DV_N];
  logic [31:0] dv_den_r [DV_N];
  flag_t       dv_f_r   [DV_N];

  logic [57:0] dv_rem_src [DV_N];
  logic [25:0] dv_q_src   [DV_N];
  logic [31:0] dv_den_src [DV_N];
  logic [57:0] dv_trial   [DV_N];
  logic [57:0] dv_rem_nxt [DV_N];
  logic [25:0] dv_q_nxt   [DV_N];

  always_comb begin
    dv_rem_src[0] = {1'b0, cl_num_r, 24'b0};
    dv_q_src[0]   = '0;
    dv_den_src[0] = cl_den_r;
    for (int j = 1; j < DV_N; j++) begin
      dv_rem_src[j] = dv_rem_r[j-1];
      dv_q_src[j]   = dv_q_r[j-1];
      dv_den_src[j] = dv_den_r[j-1];
    end
    for (int j = 0; j < DV_N; j++) begin
      dv_trial[j]   = 58'(dv_den_src[j]) << (DV_N - 1 - j);
      dv_rem_nxt[j] = dv_rem_src[j];
      dv_q_nxt[j]   = dv_q_src[j];
      if (dv_rem_src[j] >= dv_trial[j]) begin
        dv_rem_nxt[j] = dv_rem_src[j] - dv_trial[j];
        dv_q_nxt[j]   = dv_q_src[j] | (26'(1) << (DV_N - 1 - j));
      end
    end
  end

  // ---------------- energy product and rounding ----------------
  logic [49:0] pr_r;
  flag_t       pr_f_r;
  logic [26:0] e_round;

  always_comb begin
    e_round = 27'(({1'b0, pr_r} + ENERGY_HALF) >> 24);
    res_nxt.zero_bond   = pr_f_r.zb;
    if (pr_f_r.kill || pr_f_r.zb)  res_nxt.bend_energy = '0;
    else if (e_round > ENERGY_MAX) res_nxt.bend_energy = 25'(ENERGY_MAX);
    else                           res_nxt.bend_energy = 25'(e_round);
  end

  // ---------------- pipeline data registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_f_r <= '0;
      s2_f_r <= '0;
      s3_f_r <= '0;
      s4_f_r <= '0;
      s5_f_r <= '0;
      s6_f_r <= '0;
      dn_f_r <= '0;
      nu_f_r <= '0;
      cl_f_r <= '0;
      pr_f_r <= '0;
      for (int j = 0; j < SQ_N; j++)  sq_f_r[j] <= '0;
      for (int j = 0; j < NRM_N; j++) nm_f_r[j] <= '0;
      for (int j = 0; j < DV_N; j++)  dv_f_r[j] <= '0;
    end else if (en) begin
      s1_f_r.kill <= (stiff_r == '0) || (idx_ext < IDX_CMP_W'(2))
                  || (idx_ext >= IDX_CMP_W'(CHAIN_LEN));
      s1_f_r.zb   <= 1'b0;
      s2_f_r <= s1_f_r;
      s3_f_r <= s2_f_r;
      s4_f_r <= s3_f_r;
      s5_f_r <= s4_f_r;
      s6_f_r <= s6_f_nxt;
      sq_f_r[0] <= s6_f_r;
      for (int j = 1; j < SQ_N; j++) sq_f_r[j] <= sq_f_r[j-1];
      dn_f_r <= sq_f_r[SQ_N-1];
      nu_f_r <= dn_f_r;
      nm_f_r[0] <= nu_f_r;
      for (int j = 1; j < NRM_N; j++) nm_f_r[j] <= nm_f_r[j-1];
      cl_f_r <= nm_f_r[NRM_N-1];
      dv_f_r[0] <= cl_f_r;
      for (int j = 1; j < DV_N; j++) dv_f_r[j] <= dv_f_r[j-1];
      pr_f_r <= dv_f_r[DV_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        s1_d_r[j]  <= s1_d_nxt[j];
        s2_t_r[j]  <= s2_t_nxt[j];
        s2_d_r[j]  <= s1_d_r[j];
        s3_ne_r[j] <= s3_ne_nxt[j];
        s3_d_r[j]  <= s2_d_r[j];
        s4_w_r[j]  <= s4_w_nxt[j];
      end
      for (int j = 0; j < 9; j++) s5_p_r[j] <= s5_p_nxt[j];
      s6_l1_r  <= 52'(s6_l1_sum);
      s6_l2_r  <= 52'(s6_l2_sum);
      s6_dot_r <= s6_dot_sum;
      for (int j = 0; j < SQ_N; j++) begin
        sq_rem1_r[j] <= sq_rem1_nxt[j];
        sq_rem2_r[j] <= sq_rem2_nxt[j];
        sq_rt1_r[j]  <= sq_rt1_nxt[j];
        sq_rt2_r[j]  <= sq_rt2_nxt[j];
      end
      sq_dot_r[0] <= s6_dot_r;
      for (int j = 1; j < SQ_N; j++) sq_dot_r[j] <= sq_dot_r[j-1];
      dn_den_r <= sq_rt1_r[SQ_N-1] * sq_rt2_r[SQ_N-1];
      dn_dot_r <= sq_dot_r[SQ_N-1];
      nu_num_r <= nu_num_nxt;
      nu_den_r <= dn_den_r;
      for (int j = 0; j < NRM_N; j++) begin
        nm_num_r[j] <= nm_num_nxt[j];
        nm_den_r[j] <= nm_den_nxt[j];
      end
      cl_num_r <= cl_num_nxt;
      cl_den_r <= nm_den_r[NRM_N-1][31:0];
      for (int j = 0; j < DV_N; j++) begin
        dv_rem_r[j] <= dv_rem_nxt[j];
        dv_q_r[j]   <= dv_q_nxt[j];
        dv_den_r[j] <= dv_den_src[j];
      end
      pr_r <= 50'(stiff_r) * 50'(dv_q_r[DV_N-1]);
    end
  end

endmodule

// ===== dv/tb_bending_energy_min_image.sv =====
`timescale 1ns / 1ps
// Testbench for bending_energy_min_image: directed and random bead triples over
// several box and stiffness settings, checked against a scoreboard. Uses bemi_pkg.
module tb_bending_energy_min_image;
  import bemi_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int CHAIN = 1024;
  localparam int PIPE_DEPTH = 73;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 190;

  // Energy predictor and store of expected results
  class energy_scoreboard;
    logic [23:0] stiff;
    logic [22:0] edge_len[3];
    logic [23:0] inv_len[3];
    bemi_out_t   expected_q[$];
    int          errors;

    function void reset_regs();
      stiff = '0;
      for (int i = 0; i < 3; i++) begin
        edge_len[i] = '0;
        inv_len[i]  = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
      case (idx)
        REG_BEND_STIFFNESS: stiff = val;
        REG_EDGE_X:         edge_len[0] = val[22:0];
        REG_EDGE_Y:         edge_len[1] = val[22:0];
        REG_EDGE_Z:         edge_len[2] = val[22:0];
        REG_INV_EDGE_X:     inv_len[0] = val;
        REG_INV_EDGE_Y:     inv_len[1] = val;
        REG_INV_EDGE_Z:     inv_len[2] = val;
        default: ;
      endcase
    endfunction

    // Minimum-image wrap of one component, saturated to Q.14 bounds
    function longint min_image(longint d, longint e, longint inv);
      longint n, w;
      n = (d * inv + (longint'(1) << 37)) >>> 38;
      w = d - n * e;
      if (w > 33554431) w = 33554431;
      if (w < -33554432) w = -33554432;
      return w;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else r = r >> 1;
        b = b >> 2;
      end
      return r;
    endfunction

    function bemi_out_t predict(bemi_in_t it);
      bemi_out_t res;
      longint pa[3], pb[3], pc[3], ba, cb, l1, l2, dot, dot_s;
      longint unsigned len1, len2, den, num, ratio, e;
      res = '0;
      if (stiff == 0 || it.index_in_chain < 2 || it.index_in_chain >= CHAIN) return res;
      pa = '{it.a_x, it.a_y, it.a_z};
      pb = '{it.b_x, it.b_y, it.b_z};
      pc = '{it.c_x, it.c_y, it.c_z};
      l1 = 0; l2 = 0; dot = 0;
      for (int d = 0; d < 3; d++) begin
        ba = min_image(pb[d] - pa[d], edge_len[d], inv_len[d]);
        cb = min_image(pc[d] - pb[d], edge_len[d], inv_len[d]);
        l1 += ba * ba;
        l2 += cb * cb;
        dot += ba * cb;
      end
      if (l1 == 0 || l2 == 0) begin
        res.zero_bond = 1'b1;
        return res;
      end
      len1 = int_sqrt(longint'(l1) << 10);
      len2 = int_sqrt(longint'(l2) << 10);
      den = len1 * len2;
      dot_s = dot * 1024;
      if (dot_s >= 0) num = (den > dot_s) ? den - dot_s : 0;
      else num = den + longint'(-dot_s);
      while (den >= (64'd1 << 32)) begin
        den = den >> 1;
        num = num >> 1;
      end
      if (num > 2 * den) num = 2 * den;
      ratio = (num << 24) / den;
      e = (longint'(stiff) * ratio + (64'd1 << 23)) >> 24;
      if (e > 33554431) e = 33554431;
      res.bend_energy = e[24:0];
      return res;
    endfunction

    function void note_input(bemi_in_t it);
      expected_q.push_back(predict(it));
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(bemi_out_t got);
      bemi_out_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.bend_energy !== want.bend_energy)
        report($sformatf("bend_energy %0d, expected %0d", got.bend_energy, want.bend_energy));
      if (got.zero_bond !== want.zero_bond)
        report($sformatf("zero_bond %0b, expected %0b", got.zero_bond, want.zero_bond));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  bemi_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bemi_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  energy_scoreboard sb;
  int hold_cycles = 0;
  int cycles = 0;

  bending_energy_min_image #(.CHAIN_LEN(CHAIN)) DUT (.*);

  always #4 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result check, sampled mid-cycle where all signals are settled
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Receiver stall: long hold on request, else a shifting random pattern
  initial begin
    int mode;
    mode = 0;
    forever begin
      @(posedge clk);
      if (cycles % 64 == 0) mode = $urandom_range(0, 2);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Write every register of one setting, then the unused index
  task write_regs(logic [23:0] vals[7]);
    for (int i = 0; i <= 7; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (i == 7) ? REG_UNUSED : CFG_IDX_W'(i);
      cfg_data  <= (i == 7) ? 24'($urandom) : vals[i];
      do @(negedge clk); while (!cfg_ready);
      sb.write_reg((i == 7) ? REG_UNUSED : CFG_IDX_W'(i), (i == 7) ? 24'd0 : vals[i]);
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one item and return at the edge that accepts it
  task send_item(bemi_in_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(negedge clk); while (in_stall);
    sb.note_input(it);
    @(posedge clk);
  endtask

  task drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 8) @(posedge clk);
  endtask

  function automatic bemi_in_t make_triple(logic [9:0] idx, logic [23:0] ax, logic [23:0] ay,
                                           logic [23:0] az, int dx1, int dy1, int dz1,
                                           int dx2, int dy2, int dz2);
    bemi_in_t it;
    it.index_in_chain = idx;
    it.a_x = ax; it.a_y = ay; it.a_z = az;
    it.b_x = 24'(ax + dx1); it.b_y = 24'(ay + dy1); it.b_z = 24'(az + dz1);
    it.c_x = 24'(it.b_x + dx2); it.c_y = 24'(it.b_y + dy2); it.c_z = 24'(it.b_z + dz2);
    return it;
  endfunction

  function automatic bemi_in_t random_item();
    bemi_in_t it;
    int sel, span;
    sel = $urandom_range(0, 9);
    span = 1 << $urandom_range(4, 20);
    if (sel < 2) begin
      it = bemi_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    end else begin
      it = make_triple(10'($urandom_range(2, 1023)), 24'($urandom), 24'($urandom),
                       24'($urandom),
                       $urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
                       $urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
                       $urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span);
      if (sel == 2) it.index_in_chain = 10'($urandom_range(0, 1));
      if (sel == 3 && $urandom_range(0, 2) == 0) begin
        it.b_x = it.a_x; it.b_y = it.a_y; it.b_z = it.a_z;
      end
    end
    return it;
  endfunction

  // Random items in bursts with random gaps
  task send_random(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && n > 0; i++) begin
        send_item(random_item());
        n--;
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  function automatic logic [23:0] inverse_of(logic [22:0] e);
    return 24'((64'd1 << 38) / e);
  endfunction

  initial begin
    logic [23:0] regs[7];
    logic [22:0] ex, ey, ez;
    sb = new();
    sb.reset_regs();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: stiffness zero gives no energy
    send_item(make_triple(10'd5, 24'd0, 24'd0, 24'd0, 100, 0, 0, 0, 100, 0));
    send_item(random_item());
    drain();

    // Unit stiffness, cubic box of 10
    ex = 23'd163840;
    regs = '{24'h010000, ex, ex, ex, inverse_of(ex), inverse_of(ex), inverse_of(ex)};
    write_regs(regs);
    send_item(make_triple(10'd0, 24'd0, 24'd0, 24'd0, 16384, 0, 0, 0, 16384, 0));
    send_item(make_triple(10'd1, 24'd0, 24'd0, 24'd0, 16384, 0, 0, 0, 16384, 0));
    send_item(make_triple(10'd2, 24'd0, 24'd0, 24'd0, 16384, 0, 0, 0, 16384, 0));
    send_item(make_triple(10'd1023, 24'd0, 24'd0, 24'd0, 16384, 0, 0, 16384, 0, 0));
    send_item(make_triple(10'd7, 24'd0, 24'd0, 24'd0, 16384, 0, 0, -16384, 0, 0));
    send_item(make_triple(10'd7, 24'd5, 24'd5, 24'd5, 0, 0, 0, 16384, 0, 0));
    send_item(make_triple(10'd7, 24'd5, 24'd5, 24'd5, 16384, 0, 0, 0, 0, 0));
    send_item(make_triple(10'd7, 24'd0, 24'd0, 24'd0, 163840, 0, 0, 0, 16384, 0));
    send_item(make_triple(10'd9, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1, 0, 0, 0, 1, 0));
    send_item(make_triple(10'd9, 24'h800000, 24'h800000, 24'h800000, -1, -1, -1, 1, 1, 1));
    send_item(make_triple(10'd9, 24'h7FFFFF, 24'h800000, 24'd0, 3, 7, 0, 0, -5, 2));
    send_item(make_triple(10'd3, 24'd0, 24'd0, 24'd0, 147456, 0, 0, 0, 16384, 0));
    send_random(ITEMS_PER_PHASE);
    drain();

    // Extremes, inconsistent box; long receiver hold fills the pipeline
    regs = '{24'hFFFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
    write_regs(regs);
    hold_cycles = 300;
    send_item(make_triple(10'd8, 24'd0, 24'd0, 24'd0, 16384, 0, 0, -16384, 0, 0));
    send_random(ITEMS_PER_PHASE);
    drain();

    // Smallest nonzero stiffness, no wrap
    regs = '{24'd1, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
    write_regs(regs);
    send_item(make_triple(10'd8, 24'd0, 24'd0, 24'd0, 16384, 0, 0, -16384, 0, 0));
    send_random(ITEMS_PER_PHASE);
    drain();

    // Random settings with consistent, differing box lengths
    repeat (3) begin
      ex = 23'($urandom_range(32768, 1 << 22));
      ey = 23'($urandom_range(16384, 1 << 20));
      ez = 23'($urandom_range(16384, 8388607));
      regs = '{24'($urandom), ex, ey, ez, inverse_of(ex), inverse_of(ey), inverse_of(ez)};
      write_regs(regs);
      send_random(ITEMS_PER_PHASE);
      drain();
    end

    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
